>>> rtl/tdpt_pkg.sv
// Shared types for the trial-division primality tester.
`default_nettype none

package tdpt_pkg;

    // Status returned by the remainder unit to the sequencer.
    typedef struct packed {
        logic done;       // one-cycle pulse when the remainder is final
        logic rem_zero;   // remainder was zero (divisor divides the value)
    } t_rem_sts;

endpackage

`default_nettype wire

>>> rtl/trial_division_prime_test.sv
// Top level of the trial-division primality tester: handshakes and sequencer.
`default_nettype none

// Usage: an item (i_value, signed two's complement) enters when i_valid is high
// and o_stall is low. The block then works on that item alone and holds o_stall
// high until the answer has moved into the output register. The answer appears
// on o_prime_flag with o_valid high and is taken at an edge where i_stall is low.
// Values of one or less, and all negative values, give 0 without any trial.
// Otherwise divisors d = 2, 3, ... are tried while d*d <= value; d*d is kept
// by adding 2d+1 per step, so the bound check is one add and compare. Each
// trial runs the shared remainder unit between the bound step and the result
// step. A 32-bit prime near the top of the range needs about 46340 trials.
// The next item can be taken in the cycle after the answer loads.
// A finished answer waiting in the output register does not block a new item;
// only the next answer waits until the receiver drops i_stall.
// Reset (i_rst_n low at a clock edge) returns to idle and empties the output.

module trial_division_prime_test
    import tdpt_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [VALUE_WIDTH-1:0] i_value,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic                        o_prime_flag
);

    // Divisors never exceed about 2^((W-1)/2) + 1.
    localparam int DW = VALUE_WIDTH / 2 + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_BOUND,
        S_WAIT,
        S_DONE
    } t_state;

    t_state                 r_state;
    logic [VALUE_WIDTH-1:0] r_v;
    logic [DW-1:0]          r_d;
    logic [VALUE_WIDTH:0]   r_sq;
    logic                   r_flag;
    logic                   r_out_valid;
    logic                   r_out_flag;

    logic                   start;
    logic                   sq_over;
    logic                   out_load;
    t_rem_sts               rem_sts;

    // The square bound is exceeded: no divisor left to try, the value is prime.
    assign sq_over  = (r_sq > {1'b0, r_v});
    assign start    = (r_state == S_BOUND) && !sq_over;
    // The answer moves out when the output register is empty or being taken.
    assign out_load = (r_state == S_DONE) && (!r_out_valid || !i_stall);

    tdpt_rem_unit #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_dividend (r_v),
        .i_divisor  (VALUE_WIDTH'(r_d)),
        .o_sts      (rem_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out_flag  <= r_flag;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_v     <= i_value;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    // Negative, zero and one are not prime.
                    if (r_v[VALUE_WIDTH-1] || r_v <= VALUE_WIDTH'(1)) begin
                        r_flag  <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_d     <= DW'(2);
                        r_sq    <= (VALUE_WIDTH + 1)'(4);
                        r_state <= S_BOUND;
                    end
                end
                S_BOUND: begin
                    if (sq_over) begin
                        r_flag  <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (rem_sts.done) begin
                        if (rem_sts.rem_zero) begin
                            r_flag  <= 1'b0;
                            r_state <= S_DONE;
                        end else begin
                            // (d+1)^2 = d^2 + 2d + 1
                            r_sq    <= r_sq + (VALUE_WIDTH + 1)'({r_d, 1'b1});
                            r_d     <= r_d + 1'b1;
                            r_state <= S_BOUND;
                        end
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_prime_flag = r_out_flag;

`ifndef NO_ASSERTIONS
    a_prime_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_flag) |-> (!r_v[VALUE_WIDTH-1] && r_v > VALUE_WIDTH'(1)))
        else $error("prime reported for a value below two");
    a_start_only_in_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> (r_state == S_WAIT))
        else $error("division started outside the bound step");
    a_done_only_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rem_sts.done |-> (r_state == S_WAIT))
        else $error("remainder finished while the sequencer was not waiting");
    a_divisor_above_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) |-> (r_d >= DW'(2)))
        else $error("trial divisor below two");
`endif

endmodule

`default_nettype wire

>>> rtl/tdpt_rem_unit.sv
// Iterative restoring remainder unit, one quotient bit per cycle.
`default_nettype none

module tdpt_rem_unit
    import tdpt_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [VALUE_WIDTH-1:0] i_dividend,
    input  wire logic [VALUE_WIDTH-1:0] i_divisor,
    output t_rem_sts                    o_sts
);

    localparam int CW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

    logic                   r_busy;
    logic [CW-1:0]          r_cnt;
    logic [VALUE_WIDTH-1:0] r_dvd;
    logic [VALUE_WIDTH-1:0] r_dvs;
    logic [VALUE_WIDTH-1:0] r_rem;
    t_rem_sts               r_sts;

    logic [VALUE_WIDTH:0]   n_shift;
    logic [VALUE_WIDTH:0]   n_diff;
    logic [VALUE_WIDTH-1:0] n_rem;

    // Bring down the next dividend bit and subtract the divisor if it fits.
    always_comb begin
        n_shift = {r_rem, r_dvd[VALUE_WIDTH-1]};
        n_diff  = n_shift - {1'b0, r_dvs};
        if (n_diff[VALUE_WIDTH]) begin
            n_rem = n_shift[VALUE_WIDTH-1:0];
        end else begin
            n_rem = n_diff[VALUE_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_sts  <= '0;
        end else begin
            // Done pulses for one cycle after the last quotient bit.
            r_sts.done <= !i_start && r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(VALUE_WIDTH - 1);
                r_dvd  <= i_dividend;
                r_dvs  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dvd <= {r_dvd[VALUE_WIDTH-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy         <= 1'b0;
                    r_sts.rem_zero <= (n_rem == '0);
                end
            end
        end
    end

    assign o_sts = r_sts;

`ifndef NO_ASSERTIONS
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sts.done |=> !r_sts.done)
        else $error("remainder done held longer than one cycle");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sts.done |-> $past(r_busy))
        else $error("remainder done without a running division");
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_dvs != '0) |-> (r_rem < r_dvs))
        else $error("partial remainder not below divisor");
`endif

endmodule

`default_nettype wire

>>> sim/tb_trial_division_prime_test.sv
// Self-checking testbench for the trial-division primality tester.
module tb_trial_division_prime_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW = 32;

    // The slowest item is the largest positive prime, which needs the most trials.
    // Everything else is quick to answer, so this limit leaves a wide margin.
    localparam int CYCLE_LIMIT = 20_000_000;

    // Number of quiet cycles after the last answer, to catch stray results.
    localparam int SETTLE_CYCLES = 50;

    typedef struct {
        logic [VW-1:0] value;
        bit            prime;
    } t_answer;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic [VW-1:0] i_value = '0;
    logic          i_stall = 1'b0;
    logic          o_stall;
    logic          o_valid;
    logic          o_prime_flag;

    // Answers for accepted items, oldest first.
    t_answer pending_answers[$];

    int error_count = 0;
    int cycle_count = 0;

    // Idle rates in percent for the two sides of the block.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    // A long receiver hold-off is requested by setting its length and then
    // bumping the request count. Only the receiver process counts it down.
    int hold_len = 0;
    int hold_requests = 0;
    int hold_seen = 0;
    int hold_left = 0;

    trial_division_prime_test #(
        .VALUE_WIDTH(VW)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_prime_flag(o_prime_flag)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // Primality by trial division. The bound is written as d <= n / d so that
    // it cannot overflow for values near the top of the range.
    function automatic bit is_prime_value(input logic [VW-1:0] v);
        longint unsigned n;
        longint unsigned d;
        if (v[VW-1]) begin
            return 1'b0;
        end
        n = v;
        if (n <= 1) begin
            return 1'b0;
        end
        for (d = 2; d <= n / d; d++) begin
            if (n % d == 0) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Offers one item and returns once it has been accepted. Valid is left high,
    // so back-to-back items keep it up; the next call lowers it only to idle, and the drain lowers it.
    task automatic send_value(input logic [VW-1:0] v);
        t_answer a;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        a.value = v;
        a.prime = is_prime_value(v);
        pending_answers.push_back(a);
    endtask

    // Stops offering items and waits until every accepted item has been answered.
    task automatic wait_for_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_answers.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Random values are mostly small so that each test stays short. Products and
    // squares of small numbers exercise divisors well past 2 and the case where
    // d*d equals the value. Wide values are kept negative or even, which makes
    // them quick to answer while every bit of the word still toggles.
    function automatic logic [VW-1:0] random_value();
        int unsigned sel;
        int unsigned p;
        int unsigned q;
        logic [VW-1:0] w;
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            w = $urandom_range(0, 3000);
        end else if (sel < 55) begin
            w = $urandom_range(3001, 65535);
        end else if (sel < 70) begin
            p = $urandom_range(2, 250);
            q = $urandom_range(2, 250);
            w = p * q;
        end else if (sel < 80) begin
            p = $urandom_range(2, 250);
            w = p * p;
        end else begin
            w = $urandom;
            if (!w[VW-1]) begin
                w[0] = 1'b0;
            end
        end
        return w;
    endfunction

    // Directed values: the extremes of the signed range, the values that are
    // never prime, two and three where no divisor is tried, squares of primes
    // where the bound is met exactly, and the largest positive value.
    task automatic test_directed();
        logic [VW-1:0] values[$];
        values = '{32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd0, 32'd1,
                   32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25, 32'd49, 32'd97,
                   32'd65521, 32'd65535, 32'd1000003, 32'h4000_0000,
                   32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h5555_5554, 32'hAAAA_AAAA};
        foreach (values[k]) begin
            send_value(values[k]);
        end
        wait_for_results();
    endtask

    task automatic test_random(input int count);
        for (int k = 0; k < count; k++) begin
            send_value(random_value());
        end
        wait_for_results();
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering
    // quick items. The output register fills, the block stalls its input, and
    // everything drains in order once the hold-off ends.
    task automatic test_backpressure();
        hold_len = 2000;
        hold_requests++;
        for (int k = 0; k < 12; k++) begin
            send_value($urandom_range(0, 120));
        end
        wait_for_results();
    endtask

    // The sender pauses after each item until its answer has arrived, so every
    // item starts on a block that is completely idle.
    task automatic test_drain_pause();
        for (int k = 0; k < 5; k++) begin
            send_value(random_value());
            wait_for_results();
        end
    endtask

    // Receiver: random stall at each falling edge, plus the long hold-off when
    // one is requested. The hold-off is counted here in cycles.
    always @(negedge i_clk) begin
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // Each answer taken from the block is checked against the oldest one waiting.
    always @(posedge i_clk) begin
        t_answer a;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_answers.size() == 0) begin
                report_mismatch($sformatf("result %0b with no item waiting", o_prime_flag));
            end else begin
                a = pending_answers.pop_front();
                if (o_prime_flag !== a.prime) begin
                    report_mismatch($sformatf("value %0d: prime_flag %b, expected %b",
                                              $signed(a.value), o_prime_flag, a.prime));
                end
            end
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_trial_division_prime_test: errors");
        $finish;
    end

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Slow receiver, moderately busy sender.
        tx_idle_pct = 35;
        rx_idle_pct = 79;
        test_directed();
        test_random(25);

        // Slow sender, moderately busy receiver.
        tx_idle_pct = 79;
        rx_idle_pct = 35;
        test_random(25);
        test_backpressure();

        // Neither side idles.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random(20);
        test_drain_pause();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_answers.size() == 0) begin
            $display("tb_trial_division_prime_test: clean");
        end else begin
            $display("tb_trial_division_prime_test: errors");
        end
        $finish;
    end

endmodule

>>> trial_division_prime_test.f
rtl/tdpt_pkg.sv
rtl/tdpt_rem_unit.sv
rtl/trial_division_prime_test.sv
sim/tb_trial_division_prime_test.sv
